### sv/klbs_pkg.sv
// Package for the keyed list with bubble sort.
// Holds the sizes, codes and controller/datapath interface types.
// No dependencies.
package klbs_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int HANDLE_W = 16;
    localparam int KEY_W    = 16;
    localparam int POS_W    = 6;
    localparam int CMP_W    = POS_W + CNT_W;
    localparam int IN_W     = ((HANDLE_W + KEY_W + POS_W + 7) / 8) * 8;
    localparam int OUT_W    = ((HANDLE_W + KEY_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TAKE   = 2'd1,
        OP_PEEK   = 2'd2,
        OP_SORT   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_POS   = 2'd0,
        RD_ZERO  = 2'd1,
        RD_NEXT  = 2'd2,
        RD_NEXT2 = 2'd3
    } t_rd_sel;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } t_entry;

    typedef struct packed {
        logic    capture;
        t_rd_sel rd_sel;
        logic    app_wr;
        logic    idx_pos;
        logic    sort_init;
        logic    res_zero;
        t_status res_st;
        logic    res_rd;
        logic    shift_wr;
        logic    dec_count;
        logic    carry_load;
        logic    srt_step;
        logic    srt_end;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic bad;
        logic take_last;
        logic shift_last;
        logic few;
        logic srt_last;
        logic srt_more;
    } t_sts;

endpackage

### sv/keyed_list_with_bubble_sort_top.sv
// Keyed list with bubble sort: top level, one transfer in, one result out.
// Take moves the entries behind the position down one place (count - 1 - position
// of them), one entry per cycle from the single store write port; sort makes
// passes over the store.
// One item at a time; the next is taken once the result sits in the output register.
// Synchronous active-low reset clears the list count and control; entries are not cleared.
module keyed_list_with_bubble_sort_top
    import klbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // entry_handle, entry_key, position, zero fill
    input  logic [1:0]       i_s_tuser,   // op
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // result_handle, result_key, count, zero fill
    output logic [1:0]       o_m_tuser    // status
);

    t_cmd cmd;
    t_sts sts;

    klbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    klbs_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

endmodule

### sv/klbs_dp.sv
// Datapath of the keyed list: entry store, count, index and sort registers.
// Executes the commands of klbs_ctrl; depends on klbs_pkg.
module klbs_dp
    import klbs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [IN_W-1:0]     i_s_tdata,
    input  logic [1:0]          i_s_tuser,
    output logic [OUT_W-1:0]    o_m_tdata,
    output logic [1:0]          o_m_tuser
);

    t_entry              r_mem [CAPACITY];
    t_entry              r_rdata;
    t_op                 r_op;
    logic [HANDLE_W-1:0] r_h;
    logic [KEY_W-1:0]    r_k;
    logic [POS_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_idx;
    logic [CNT_W-1:0]    r_limit;
    t_entry              r_carry;
    logic                r_moved;
    t_entry              r_res;
    t_status             r_res_st;
    t_entry              r_out;
    t_status             r_out_st;
    logic [CNT_W-1:0]    r_out_count;

    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    t_entry              wr_data;
    logic                swap;

    assign swap = r_carry.key > r_rdata.key;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_POS:   rd_addr = ADDR_W'(r_pos);
            RD_ZERO:  rd_addr = '0;
            RD_NEXT:  rd_addr = r_idx + ADDR_W'(1);
            RD_NEXT2: rd_addr = r_idx + ADDR_W'(2);
            default:  rd_addr = '0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_carry;
        if (i_cmd.app_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_count[ADDR_W-1:0];
            wr_data = '{handle: r_h, key: r_k};
        end else if (i_cmd.shift_wr) begin
            wr_en   = 1'b1;
            wr_data = r_rdata;
        end else if (i_cmd.srt_step) begin
            wr_en   = 1'b1;
            wr_data = swap ? r_rdata : r_carry;
        end else if (i_cmd.srt_end) begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.app_wr) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.dec_count) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_s_tuser);
            r_h   <= i_s_tdata[HANDLE_W-1:0];
            r_k   <= i_s_tdata[HANDLE_W+KEY_W-1:HANDLE_W];
            r_pos <= i_s_tdata[HANDLE_W+KEY_W+POS_W-1:HANDLE_W+KEY_W];
        end
        if (i_cmd.idx_pos) begin
            r_idx <= ADDR_W'(r_pos);
        end else if (i_cmd.sort_init || i_cmd.srt_end) begin
            r_idx <= '0;
        end else if (i_cmd.shift_wr || i_cmd.srt_step) begin
            r_idx <= r_idx + ADDR_W'(1);
        end
        if (i_cmd.sort_init) begin
            r_limit <= r_count;
        end else if (i_cmd.srt_end) begin
            r_limit <= r_limit - CNT_W'(1);
        end
        if (i_cmd.carry_load) begin
            r_carry <= r_rdata;
            r_moved <= 1'b0;
        end else if (i_cmd.srt_step) begin
            if (swap) begin
                r_moved <= 1'b1;
            end else begin
                r_carry <= r_rdata;
            end
        end
        if (i_cmd.res_zero) begin
            r_res    <= '0;
            r_res_st <= i_cmd.res_st;
        end else if (i_cmd.res_rd) begin
            r_res    <= r_rdata;
            r_res_st <= ST_OK;
        end
        if (i_cmd.out_load) begin
            r_out       <= r_res;
            r_out_st    <= r_res_st;
            r_out_count <= r_count;
        end
    end

    always_comb begin
        o_sts.op         = r_op;
        o_sts.full       = r_count == CNT_W'(CAPACITY);
        o_sts.bad        = CMP_W'(r_pos) >= CMP_W'(r_count);
        o_sts.take_last  = CNT_W'(r_idx) + CNT_W'(1) == r_count;
        o_sts.shift_last = CNT_W'(r_idx) + CNT_W'(2) == r_count;
        o_sts.few        = r_count < CNT_W'(2);
        o_sts.srt_last   = CNT_W'(r_idx) + CNT_W'(2) == r_limit;
        o_sts.srt_more   = r_moved && (r_limit > CNT_W'(2));
    end

    assign o_m_tdata = OUT_W'({r_out_count, r_out.key, r_out.handle});
    assign o_m_tuser = r_out_st;

endmodule

### sv/klbs_ctrl.sv
// Controller of the keyed list: sequences append, take, peek and sort.
// Drives klbs_dp by command and status structs; depends on klbs_pkg.
module klbs_ctrl
    import klbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_FETCH    = 8'b0000_0100,
        S_SHIFT    = 8'b0000_1000,
        S_SRT_LOAD = 8'b0001_0000,
        S_SRT_STEP = 8'b0010_0000,
        S_SRT_END  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_APPEND: begin
                        o_cmd.res_zero = 1'b1;
                        o_cmd.res_st   = i_sts.full ? ST_FULL : ST_OK;
                        o_cmd.app_wr   = !i_sts.full;
                        n_state        = S_DONE;
                    end
                    OP_TAKE, OP_PEEK: begin
                        o_cmd.rd_sel = RD_POS;
                        if (i_sts.bad) begin
                            o_cmd.res_zero = 1'b1;
                            o_cmd.res_st   = ST_RANGE;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.idx_pos = 1'b1;
                            n_state       = S_FETCH;
                        end
                    end
                    OP_SORT: begin
                        o_cmd.res_zero  = 1'b1;
                        o_cmd.res_st    = ST_OK;
                        o_cmd.sort_init = 1'b1;
                        o_cmd.rd_sel    = RD_ZERO;
                        n_state         = i_sts.few ? S_DONE : S_SRT_LOAD;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_FETCH: begin
                o_cmd.res_rd = 1'b1;
                o_cmd.rd_sel = RD_NEXT;
                if (i_sts.op == OP_PEEK) begin
                    n_state = S_DONE;
                end else if (i_sts.take_last) begin
                    o_cmd.dec_count = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.rd_sel   = RD_NEXT2;
                if (i_sts.shift_last) begin
                    o_cmd.dec_count = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_SRT_LOAD: begin
                o_cmd.carry_load = 1'b1;
                o_cmd.rd_sel     = RD_NEXT;
                n_state          = S_SRT_STEP;
            end
            S_SRT_STEP: begin
                o_cmd.srt_step = 1'b1;
                o_cmd.rd_sel   = RD_NEXT2;
                if (i_sts.srt_last) begin
                    n_state = S_SRT_END;
                end
            end
            S_SRT_END: begin
                o_cmd.srt_end = 1'b1;
                o_cmd.rd_sel  = RD_ZERO;
                n_state       = i_sts.srt_more ? S_SRT_LOAD : S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_out_valid;

endmodule
